/* rtl/bgle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgle_pkg: shared types and constants of the gate-list engine
// Word and result layouts, command codes and store geometry.
// ----------------------------------------------------------------------------
package bgle_pkg;

  localparam int RAM_WORDS     = 16384;
  localparam int OP_BITS       = 2;
  localparam int MAP_POSITIONS = 128;
  localparam int AW            = $clog2(RAM_WORDS);
  localparam int MW            = $clog2(MAP_POSITIONS);
  localparam int CMDQ_DEPTH    = 2;

  localparam logic [2:0] KIND_MAP_IN  = 3'd0;
  localparam logic [2:0] KIND_MAP_OUT = 3'd1;
  localparam logic [2:0] KIND_START   = 3'd2;
  localparam logic [2:0] KIND_PLAIN   = 3'd3;
  localparam logic [2:0] KIND_GATE    = 3'd4;
  localparam logic [2:0] KIND_READ    = 3'd5;

  typedef struct packed {
    logic [2:0]  kind;
    logic [9:0]  index;
    logic [15:0] map_addr;
    logic [7:0]  plain_byte;
    logic [7:0]  op_byte;
    logic [7:0]  dst_low;
    logic [15:0] src_a;
    logic [15:0] src_b;
  } item_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ABORT = 2'd1,
    ST_RANGE = 2'd2,
    ST_SLICE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] cipher_byte;
    status_e    status;
  } res_t;

  typedef enum logic [1:0] {
    OP_XOR = 2'd0,
    OP_AND = 2'd1,
    OP_OR  = 2'd2,
    OP_NOT = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_MAP_IN,
    CMD_MAP_OUT,
    CMD_START,
    CMD_PLAIN,
    CMD_GATE,
    CMD_READ,
    CMD_REPORT,
    CMD_GATE_BAD,
    CMD_GATE_RANGE,
    CMD_READ_SLICE
  } cmd_e;

  typedef struct packed {
    cmd_e          cmd;
    status_e       status;
    logic [MW-1:0] pos;
    logic [AW-1:0] addr;
    logic [AW-1:0] src_a;
    logic [AW-1:0] src_b;
    op_e           op;
    logic [5:0]    slot;
    logic [3:0]    nib;
    logic [7:0]    pbyte;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR_MAP,
    S_CLR_WR,
    S_PL_MAP,
    S_PL_RD,
    S_PL_WR,
    S_G_B,
    S_G_WR,
    S_RD_MAP,
    S_RD_WORD,
    S_RD_BIT
  } state_e;

endpackage

/* rtl/bitsliced_gate_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitsliced_gate_list_engine_core: bitsliced gate-list engine
// Queue-style front end, command queue, and a sequencer over the word store.
// ----------------------------------------------------------------------------
// Usage: words go in through push/full and every word yields exactly one
// result, in order, read through empty/pop. A front stage classifies each
// word (range and slice checks against slice_count) into a two-entry command
// queue; the back sequencer runs commands one at a time over a 64-bit word
// store and the two 128-entry position maps, all single read port RAMs with
// registered reads. Steps per word in the back end: map loads and every
// rejected word finish in the step that takes the command; a gate issues
// with the first word read, then reads the second word, then writes; a
// plaintext byte and a read byte issue, then per bit do a map read, a word
// read and an update; a block start issues, then does a map read plus a
// word clear for each of the 128 input positions. The next command starts
// only once the previous result word has been popped. The front keeps
// accepting while the queue has room and a finished result waits. Write
// slice_count only while idle.
module bitsliced_gate_list_engine_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  bgle_pkg::item_t item_i,
  output logic            empty,
  input  logic            pop,
  output bgle_pkg::res_t  res_o,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i
);

  logic           cmd_valid;
  logic           cmd_take;
  bgle_pkg::cmd_t cmd;

  // Accept and classify words, hold them for the back end
  bgle_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_take_i(cmd_take)
  );

  // Execute commands and hold the result word until popped
  bgle_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd),
    .cmd_take_o(cmd_take), .empty, .pop, .res_o
  );

endmodule

/* rtl/bgle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgle_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bgle_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bgle_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgle_front: input side of the gate-list engine
// Accepts words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module bgle_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  bgle_pkg::item_t  item_i,
  input  logic             cfg_we_i,
  input  logic [6:0]       cfg_wdata_i,
  output logic             cmd_valid_o,
  output bgle_pkg::cmd_t   cmd_o,
  input  logic             cmd_take_i
);

  localparam int PW = (bgle_pkg::CMDQ_DEPTH > 1) ? $clog2(bgle_pkg::CMDQ_DEPTH) : 1;
  localparam int CW = $clog2(bgle_pkg::CMDQ_DEPTH + 1);

  logic [6:0]      slice_count_q;
  logic [6:0]      eff_slices;
  logic [15:0]     dst_full;
  logic            slice_bad, map_bad, gate_bad_rng, op_bad;
  logic [bgle_pkg::OP_BITS-1:0] opc_raw;
  bgle_pkg::cmd_t  c;
  bgle_pkg::cmd_t  q_mem [bgle_pkg::CMDQ_DEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_count_q <= 7'd64;
    end else if (cfg_we_i) begin
      slice_count_q <= cfg_wdata_i;
    end
  end

  // Classify
  always_comb begin
    eff_slices   = (slice_count_q > 7'd64) ? 7'd64 : slice_count_q;
    slice_bad    = ({1'b0, item_i.index[9:4]} >= eff_slices);
    map_bad      = ({1'b0, item_i.index} >= 11'(bgle_pkg::MAP_POSITIONS)) ||
                   ({1'b0, item_i.map_addr} >= 17'(bgle_pkg::RAM_WORDS));
    dst_full     = {8'(item_i.op_byte >> bgle_pkg::OP_BITS), item_i.dst_low};
    opc_raw      = item_i.op_byte[bgle_pkg::OP_BITS-1:0];
    op_bad       = (opc_raw > bgle_pkg::OP_BITS'(3));
    gate_bad_rng = ({1'b0, dst_full} >= 17'(bgle_pkg::RAM_WORDS)) ||
                   ({1'b0, item_i.src_a} >= 17'(bgle_pkg::RAM_WORDS)) ||
                   ((opc_raw != bgle_pkg::OP_BITS'(3)) &&
                    ({1'b0, item_i.src_b} >= 17'(bgle_pkg::RAM_WORDS)));

    c        = '0;
    c.status = bgle_pkg::ST_OK;
    c.pos    = item_i.index[bgle_pkg::MW-1:0];
    c.addr   = item_i.map_addr[bgle_pkg::AW-1:0];
    c.src_a  = item_i.src_a[bgle_pkg::AW-1:0];
    c.src_b  = item_i.src_b[bgle_pkg::AW-1:0];
    c.op     = bgle_pkg::op_e'(opc_raw[1:0]);
    c.slot   = item_i.index[9:4];
    c.nib    = item_i.index[3:0];
    c.pbyte  = item_i.plain_byte;
    unique case (item_i.kind) inside
      bgle_pkg::KIND_MAP_IN, bgle_pkg::KIND_MAP_OUT: begin
        if (map_bad) begin
          c.cmd    = bgle_pkg::CMD_REPORT;
          c.status = bgle_pkg::ST_RANGE;
        end else begin
          c.cmd = (item_i.kind == bgle_pkg::KIND_MAP_IN) ? bgle_pkg::CMD_MAP_IN
                                                          : bgle_pkg::CMD_MAP_OUT;
        end
      end
      bgle_pkg::KIND_START: c.cmd = bgle_pkg::CMD_START;
      bgle_pkg::KIND_PLAIN: begin
        if (slice_bad) begin
          c.cmd    = bgle_pkg::CMD_REPORT;
          c.status = bgle_pkg::ST_SLICE;
        end else begin
          c.cmd = bgle_pkg::CMD_PLAIN;
        end
      end
      bgle_pkg::KIND_GATE: begin
        c.addr = dst_full[bgle_pkg::AW-1:0];
        if (op_bad) begin
          c.cmd = bgle_pkg::CMD_GATE_BAD;
        end else if (gate_bad_rng) begin
          c.cmd = bgle_pkg::CMD_GATE_RANGE;
        end else begin
          c.cmd = bgle_pkg::CMD_GATE;
        end
      end
      bgle_pkg::KIND_READ: begin
        c.cmd = slice_bad ? bgle_pkg::CMD_READ_SLICE : bgle_pkg::CMD_READ;
      end
      default: begin
        c.cmd    = bgle_pkg::CMD_REPORT;
        c.status = bgle_pkg::ST_ABORT;
      end
    endcase
  end

  // Command queue
  assign full        = (cnt_q == CW'(bgle_pkg::CMDQ_DEPTH));
  assign do_push     = push && !full;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PW'(bgle_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (cmd_take_i) begin
        rd_q <= (rd_q == PW'(bgle_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CW'(do_push) - CW'(cmd_take_i);
    end
  end

endmodule

/* rtl/bgle_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgle_back: execution side of the gate-list engine
// Runs queued commands against the word store and the two position maps.
// ----------------------------------------------------------------------------
module bgle_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  bgle_pkg::cmd_t  cmd_i,
  output logic            cmd_take_o,
  output logic            empty,
  input  logic            pop,
  output bgle_pkg::res_t  res_o
);

  localparam int AW = bgle_pkg::AW;
  localparam int MW = bgle_pkg::MW;

  bgle_pkg::state_e state_q, state_d;
  bgle_pkg::cmd_t   cur_q, cur_d;
  logic [MW-1:0]    k_q, k_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic [63:0]      va_q, va_d;
  logic [7:0]       byte_q, byte_d, byte_n;
  logic             aborted_q, aborted_d;
  logic             res_valid_q, res_valid_d;
  bgle_pkg::res_t   res_q, res_d;
  logic             go, last8;

  logic          w_we;
  logic [AW-1:0] w_waddr, w_raddr;
  logic [63:0]   w_wdata, w_rdata, gate_r;
  logic          im_we, om_we;
  logic [MW-1:0] im_raddr, om_raddr;
  logic [AW-1:0] im_rdata, om_rdata;

  bgle_ram #(.W(64), .D(bgle_pkg::RAM_WORDS)) u_word (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );
  bgle_ram #(.W(AW), .D(bgle_pkg::MAP_POSITIONS)) u_imap (
    .clk_i, .we_i(im_we), .waddr_i(cmd_i.pos), .wdata_i(cmd_i.addr),
    .raddr_i(im_raddr), .rdata_o(im_rdata)
  );
  bgle_ram #(.W(AW), .D(bgle_pkg::MAP_POSITIONS)) u_omap (
    .clk_i, .we_i(om_we), .waddr_i(cmd_i.pos), .wdata_i(cmd_i.addr),
    .raddr_i(om_raddr), .rdata_o(om_rdata)
  );

  assign go         = cmd_valid_i && !res_valid_q && (state_q == bgle_pkg::S_IDLE);
  assign cmd_take_o = go;
  assign last8      = (k_q[2:0] == 3'd7);
  assign empty      = !res_valid_q;
  assign res_o      = res_q;

  always_comb begin
    unique case (cur_q.op)
      bgle_pkg::OP_XOR: gate_r = va_q ^ w_rdata;
      bgle_pkg::OP_AND: gate_r = va_q & w_rdata;
      bgle_pkg::OP_OR:  gate_r = va_q | w_rdata;
      default:          gate_r = ~va_q;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bgle_pkg::S_IDLE: begin
        if (go) begin
          unique case (cmd_i.cmd)
            bgle_pkg::CMD_START: state_d = bgle_pkg::S_CLR_MAP;
            bgle_pkg::CMD_PLAIN: state_d = bgle_pkg::S_PL_MAP;
            bgle_pkg::CMD_GATE:  state_d = aborted_q ? bgle_pkg::S_IDLE : bgle_pkg::S_G_B;
            bgle_pkg::CMD_READ:  state_d = aborted_q ? bgle_pkg::S_IDLE : bgle_pkg::S_RD_MAP;
            default:             state_d = bgle_pkg::S_IDLE;
          endcase
        end
      end
      bgle_pkg::S_CLR_MAP: state_d = bgle_pkg::S_CLR_WR;
      bgle_pkg::S_CLR_WR:  state_d = (k_q == MW'(bgle_pkg::MAP_POSITIONS - 1)) ?
                                     bgle_pkg::S_IDLE : bgle_pkg::S_CLR_MAP;
      bgle_pkg::S_PL_MAP:  state_d = bgle_pkg::S_PL_RD;
      bgle_pkg::S_PL_RD:   state_d = bgle_pkg::S_PL_WR;
      bgle_pkg::S_PL_WR:   state_d = last8 ? bgle_pkg::S_IDLE : bgle_pkg::S_PL_MAP;
      bgle_pkg::S_G_B:     state_d = bgle_pkg::S_G_WR;
      bgle_pkg::S_G_WR:    state_d = bgle_pkg::S_IDLE;
      bgle_pkg::S_RD_MAP:  state_d = bgle_pkg::S_RD_WORD;
      bgle_pkg::S_RD_WORD: state_d = bgle_pkg::S_RD_BIT;
      bgle_pkg::S_RD_BIT:  state_d = last8 ? bgle_pkg::S_IDLE : bgle_pkg::S_RD_MAP;
      default:             state_d = bgle_pkg::S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    cur_d       = cur_q;
    k_d         = k_q;
    addr_d      = addr_q;
    va_d        = va_q;
    byte_d      = byte_q;
    byte_n      = byte_q | (8'(w_rdata[cur_q.slot]) << (3'd7 - k_q[2:0]));
    aborted_d   = aborted_q;
    res_valid_d = res_valid_q && !pop;
    res_d       = res_q;
    w_we        = 1'b0;
    w_waddr     = addr_q;
    w_wdata     = '0;
    w_raddr     = '0;
    im_we       = 1'b0;
    om_we       = 1'b0;
    im_raddr    = '0;
    om_raddr    = '0;
    unique case (state_q)
      bgle_pkg::S_IDLE: begin
        if (go) begin
          cur_d              = cmd_i;
          k_d                = '0;
          byte_d             = '0;
          res_d.cipher_byte  = '0;
          res_d.status       = bgle_pkg::ST_OK;
          w_raddr            = cmd_i.src_a;
          unique case (cmd_i.cmd) inside
            bgle_pkg::CMD_MAP_IN: begin
              im_we       = 1'b1;
              res_valid_d = 1'b1;
            end
            bgle_pkg::CMD_MAP_OUT: begin
              om_we       = 1'b1;
              res_valid_d = 1'b1;
            end
            bgle_pkg::CMD_REPORT: begin
              res_d.status = cmd_i.status;
              res_valid_d  = 1'b1;
            end
            bgle_pkg::CMD_GATE_BAD: begin
              aborted_d    = 1'b1;
              res_d.status = bgle_pkg::ST_ABORT;
              res_valid_d  = 1'b1;
            end
            bgle_pkg::CMD_GATE_RANGE: begin
              res_d.status = aborted_q ? bgle_pkg::ST_ABORT : bgle_pkg::ST_RANGE;
              res_valid_d  = 1'b1;
            end
            bgle_pkg::CMD_READ_SLICE: begin
              res_d.status = aborted_q ? bgle_pkg::ST_ABORT : bgle_pkg::ST_SLICE;
              res_valid_d  = 1'b1;
            end
            bgle_pkg::CMD_GATE, bgle_pkg::CMD_READ: begin
              if (aborted_q) begin
                res_d.status = bgle_pkg::ST_ABORT;
                res_valid_d  = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      bgle_pkg::S_CLR_MAP: im_raddr = k_q;
      bgle_pkg::S_CLR_WR: begin
        w_we    = 1'b1;
        w_waddr = im_rdata;
        k_d     = k_q + 1'b1;
        if (k_q == MW'(bgle_pkg::MAP_POSITIONS - 1)) begin
          aborted_d   = 1'b0;
          res_valid_d = 1'b1;
        end
      end
      bgle_pkg::S_PL_MAP: im_raddr = MW'({cur_q.nib, k_q[2:0]});
      bgle_pkg::S_PL_RD: begin
        w_raddr = im_rdata;
        addr_d  = im_rdata;
      end
      bgle_pkg::S_PL_WR: begin
        w_we    = 1'b1;
        w_wdata = w_rdata ^ (64'(cur_q.pbyte[3'd7 - k_q[2:0]]) << cur_q.slot);
        k_d     = k_q + 1'b1;
        if (last8) begin
          res_valid_d = 1'b1;
        end
      end
      bgle_pkg::S_G_B: begin
        va_d    = w_rdata;
        w_raddr = cur_q.src_b;
      end
      bgle_pkg::S_G_WR: begin
        w_we        = 1'b1;
        w_waddr     = cur_q.addr;
        w_wdata     = gate_r;
        res_valid_d = 1'b1;
      end
      bgle_pkg::S_RD_MAP:  om_raddr = MW'({cur_q.nib, k_q[2:0]});
      bgle_pkg::S_RD_WORD: w_raddr = om_rdata;
      bgle_pkg::S_RD_BIT: begin
        byte_d = byte_n;
        k_d    = k_q + 1'b1;
        if (last8) begin
          res_d.cipher_byte = byte_n;
          res_valid_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bgle_pkg::S_IDLE;
      aborted_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      aborted_q   <= aborted_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    k_q    <= k_d;
    addr_q <= addr_d;
    va_q   <= va_d;
    byte_q <= byte_d;
    res_q  <= res_d;
  end

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> (state_q == bgle_pkg::S_IDLE) && !res_valid_q)
    else $error("command taken while busy");

  a_take_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |=> (state_q != bgle_pkg::S_IDLE) || res_valid_q)
    else $error("command taken but neither running nor answered");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bgle_pkg::S_CLR_WR) |-> w_we && (w_wdata == '0))
    else $error("block start writes a nonzero word");

endmodule
